// ===== src/crpm_pkg.sv =====
package crpm_pkg;

    // Configuration register map, in address order
    typedef enum logic [2:0] {
        REG_AXIS_SELECT  = 3'd0,
        REG_CENTER_A     = 3'd1,
        REG_CENTER_B     = 3'd2,
        REG_INNER_RADIUS = 3'd3,
        REG_OUTER_RADIUS = 3'd4,
        REG_AXIAL_MIN    = 3'd5,
        REG_AXIAL_MAX    = 3'd6,
        REG_MARK_VALUE   = 3'd7
    } reg_idx_t;

    localparam int REG_IDX_W = 3;

    // Mask byte
    localparam int         MASK_W     = 8;
    localparam logic [7:0] MARK_RESET = 8'hFF;
    localparam logic [7:0] MASK_CLEAR = 8'h00;

    // Register stages between input and output, output register included
    localparam int PIPE_DEPTH = 6;

endpackage

// ===== src/cylinder_region_pixel_mask_top.sv =====
// Channel   Dir  Ports                    Content
// s_        in   tvalid/tready/tdata      point x, y, z and current mask byte
// m_        out  tvalid/tready/tdata/tuser updated mask byte, hit flag
// apb       in   psel/penable/pwrite/...  region settings, 8 registers
//
// One pixel per cycle sustained while m_ is not stalled. The accepting edge loads the first of six
// register stages, and the output register, the sixth, drives m_.
// Every stage holds its own valid bit, so bubbles close up and a stalled
// output holds its result while earlier stages keep filling.
// Reset (aresetn, synchronous) empties the pipeline and restores settings;
// the radius squares follow a settings write through the squarers' partial-product and sum registers.
module cylinder_region_pixel_mask_top #(
    parameter int  COORD_BITS = 32,
    localparam int S_TDATA_W  = ((3 * COORD_BITS + crpm_pkg::MASK_W + 7) / 8) * 8,
    localparam int CFG_DATA_W = (COORD_BITS > 32) ? 64 : 32,
    localparam int CFG_ADDR_W = (COORD_BITS > 32) ? 6 : 5
) (
    input  logic                   aclk,
    input  logic                   aresetn,
    // s_tdata: coord_x, coord_y, coord_z, mask_in, zero pad to bytes
    input  logic                   s_tvalid,
    output logic                   s_tready,
    input  logic [S_TDATA_W-1:0]   s_tdata,
    // m_tdata: mask_out
    output logic                   m_tvalid,
    input  logic                   m_tready,
    output logic [7:0]             m_tdata,
    // m_tuser: hit
    output logic [0:0]             m_tuser,
    input  logic                   psel,
    input  logic                   penable,
    input  logic                   pwrite,
    input  logic [CFG_ADDR_W-1:0]  paddr,
    input  logic [CFG_DATA_W-1:0]  pwdata,
    output logic [CFG_DATA_W-1:0]  prdata,
    output logic                   pready
);

    localparam int D          = COORD_BITS;

    logic                  axis_select;
    logic [D-1:0]          center_a, center_b, axial_min, axial_max;
    logic [D-2:0]          inner_radius, outer_radius;
    logic [7:0]            mark_value;
    logic [2*D-3:0]        inner_sq, outer_sq;

    crpm_regs #(
        .COORD_BITS (COORD_BITS),
        .DATA_W     (CFG_DATA_W),
        .ADDR_W     (CFG_ADDR_W)
    ) u_regs (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .psel         (psel),
        .penable      (penable),
        .pwrite       (pwrite),
        .paddr        (paddr),
        .pwdata       (pwdata),
        .prdata       (prdata),
        .pready       (pready),
        .axis_select  (axis_select),
        .center_a     (center_a),
        .center_b     (center_b),
        .inner_radius (inner_radius),
        .outer_radius (outer_radius),
        .axial_min    (axial_min),
        .axial_max    (axial_max),
        .mark_value   (mark_value)
    );

    // Radius squares track the settings continuously
    crpm_square #(.W(D - 1)) u_sq_inner (
        .aclk   (aclk),
        .en_pp  (1'b1),
        .en_sum (1'b1),
        .val    (inner_radius),
        .sq     (inner_sq)
    );

    crpm_square #(.W(D - 1)) u_sq_outer (
        .aclk   (aclk),
        .en_pp  (1'b1),
        .en_sum (1'b1),
        .val    (outer_radius),
        .sq     (outer_sq)
    );

    crpm_pipe #(.COORD_BITS(COORD_BITS)) u_pipe (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .in_valid    (s_tvalid),
        .in_ready    (s_tready),
        .coord_x     (s_tdata[D-1:0]),
        .coord_y     (s_tdata[2*D-1:D]),
        .coord_z     (s_tdata[3*D-1:2*D]),
        .mask_in     (s_tdata[3*D+7:3*D]),
        .axis_select (axis_select),
        .center_a    (center_a),
        .center_b    (center_b),
        .axial_min   (axial_min),
        .axial_max   (axial_max),
        .mark_value  (mark_value),
        .inner_sq    (inner_sq),
        .outer_sq    (outer_sq),
        .out_valid   (m_tvalid),
        .out_ready   (m_tready),
        .mask_out    (m_tdata),
        .hit         (m_tuser[0])
    );

endmodule

// ===== src/crpm_square.sv =====
// Two-stage exact squarer: half-width partial products, then the sum.
module crpm_square #(
    parameter int W = 32
) (
    input  logic           aclk,
    input  logic           en_pp,
    input  logic           en_sum,
    input  logic [W-1:0]   val,
    output logic [2*W-1:0] sq
);

    localparam int L    = (W + 1) / 2;
    localparam int H    = W - L;
    localparam int SQ_W = 2 * W;

    logic [2*L-1:0]  pp_ll_reg;
    logic [W-1:0]    pp_lh_reg;
    logic [2*H-1:0]  pp_hh_reg;
    logic [SQ_W-1:0] sq_reg;
    logic [SQ_W-1:0] sq_next;

    logic [L-1:0] val_lo;
    logic [H-1:0] val_hi;

    assign val_lo = val[L-1:0];
    assign val_hi = val[W-1:L];

    // Stage A: partial products
    always_ff @(posedge aclk) begin
        if (en_pp) begin
            pp_ll_reg <= val_lo * val_lo;
            pp_lh_reg <= val_hi * val_lo;
            pp_hh_reg <= val_hi * val_hi;
        end
    end

    // Stage B: hi^2 << 2L + 2*hi*lo << L + lo^2
    assign sq_next = {pp_hh_reg, {(2*L){1'b0}}}
                   + SQ_W'({pp_lh_reg, {(L+1){1'b0}}})
                   + SQ_W'(pp_ll_reg);

    always_ff @(posedge aclk) begin
        if (en_sum) begin
            sq_reg <= sq_next;
        end
    end

    assign sq = sq_reg;

endmodule

// ===== src/crpm_regs.sv =====
// APB register file for the region settings.
module crpm_regs #(
    parameter int COORD_BITS = 32,
    parameter int DATA_W     = 32,
    parameter int ADDR_W     = 5
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [ADDR_W-1:0]     paddr,
    input  logic [DATA_W-1:0]     pwdata,
    output logic [DATA_W-1:0]     prdata,
    output logic                  pready,
    output logic                  axis_select,
    output logic [COORD_BITS-1:0] center_a,
    output logic [COORD_BITS-1:0] center_b,
    output logic [COORD_BITS-2:0] inner_radius,
    output logic [COORD_BITS-2:0] outer_radius,
    output logic [COORD_BITS-1:0] axial_min,
    output logic [COORD_BITS-1:0] axial_max,
    output logic [7:0]            mark_value
);

    localparam int IW = crpm_pkg::REG_IDX_W;

    logic                  axis_select_reg;
    logic [COORD_BITS-1:0] center_a_reg;
    logic [COORD_BITS-1:0] center_b_reg;
    logic [COORD_BITS-2:0] inner_radius_reg;
    logic [COORD_BITS-2:0] outer_radius_reg;
    logic [COORD_BITS-1:0] axial_min_reg;
    logic [COORD_BITS-1:0] axial_max_reg;
    logic [7:0]            mark_value_reg;

    crpm_pkg::reg_idx_t reg_idx;
    logic               wr_req;

    assign reg_idx = crpm_pkg::reg_idx_t'(paddr[ADDR_W-1 -: IW]);
    assign wr_req  = psel & penable & pwrite & pready;
    assign pready  = 1'b1;

    // Register writes
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            axis_select_reg  <= 1'b0;
            center_a_reg     <= '0;
            center_b_reg     <= '0;
            inner_radius_reg <= '0;
            outer_radius_reg <= '0;
            axial_min_reg    <= '0;
            axial_max_reg    <= '0;
            mark_value_reg   <= crpm_pkg::MARK_RESET;
        end else if (wr_req) begin
            unique case (reg_idx)
                crpm_pkg::REG_AXIS_SELECT:  axis_select_reg  <= pwdata[0];
                crpm_pkg::REG_CENTER_A:     center_a_reg     <= pwdata[COORD_BITS-1:0];
                crpm_pkg::REG_CENTER_B:     center_b_reg     <= pwdata[COORD_BITS-1:0];
                crpm_pkg::REG_INNER_RADIUS: inner_radius_reg <= pwdata[COORD_BITS-2:0];
                crpm_pkg::REG_OUTER_RADIUS: outer_radius_reg <= pwdata[COORD_BITS-2:0];
                crpm_pkg::REG_AXIAL_MIN:    axial_min_reg    <= pwdata[COORD_BITS-1:0];
                crpm_pkg::REG_AXIAL_MAX:    axial_max_reg    <= pwdata[COORD_BITS-1:0];
                crpm_pkg::REG_MARK_VALUE:   mark_value_reg   <= pwdata[7:0];
            endcase
        end
    end

    // Read mux, zero extended
    always_comb begin
        prdata = '0;
        unique case (reg_idx)
            crpm_pkg::REG_AXIS_SELECT:  prdata = DATA_W'(axis_select_reg);
            crpm_pkg::REG_CENTER_A:     prdata = DATA_W'(center_a_reg);
            crpm_pkg::REG_CENTER_B:     prdata = DATA_W'(center_b_reg);
            crpm_pkg::REG_INNER_RADIUS: prdata = DATA_W'(inner_radius_reg);
            crpm_pkg::REG_OUTER_RADIUS: prdata = DATA_W'(outer_radius_reg);
            crpm_pkg::REG_AXIAL_MIN:    prdata = DATA_W'(axial_min_reg);
            crpm_pkg::REG_AXIAL_MAX:    prdata = DATA_W'(axial_max_reg);
            crpm_pkg::REG_MARK_VALUE:   prdata = DATA_W'(mark_value_reg);
        endcase
    end

    assign axis_select  = axis_select_reg;
    assign center_a     = center_a_reg;
    assign center_b     = center_b_reg;
    assign inner_radius = inner_radius_reg;
    assign outer_radius = outer_radius_reg;
    assign axial_min    = axial_min_reg;
    assign axial_max    = axial_max_reg;
    assign mark_value   = mark_value_reg;

endmodule

// ===== src/crpm_pipe.sv =====
// Six-stage point pipeline with per-stage valid and ready.
//   1: offsets from the axis, axial window, pass-through check
//   2: absolute offsets
//   3: partial products      4: squares
//   5: squared distance      6: radius compare, output register
module crpm_pipe #(
    parameter int COORD_BITS = 32
) (
    input  logic                    aclk,
    input  logic                    aresetn,
    input  logic                    in_valid,
    output logic                    in_ready,
    input  logic [COORD_BITS-1:0]   coord_x,
    input  logic [COORD_BITS-1:0]   coord_y,
    input  logic [COORD_BITS-1:0]   coord_z,
    input  logic [7:0]              mask_in,
    input  logic                    axis_select,
    input  logic [COORD_BITS-1:0]   center_a,
    input  logic [COORD_BITS-1:0]   center_b,
    input  logic [COORD_BITS-1:0]   axial_min,
    input  logic [COORD_BITS-1:0]   axial_max,
    input  logic [7:0]              mark_value,
    input  logic [2*COORD_BITS-3:0] inner_sq,
    input  logic [2*COORD_BITS-3:0] outer_sq,
    output logic                    out_valid,
    input  logic                    out_ready,
    output logic [7:0]              mask_out,
    output logic                    hit
);

    localparam int D      = COORD_BITS;
    localparam int NS     = crpm_pkg::PIPE_DEPTH;
    localparam int DIST_W = 2 * D + 1;
    localparam int MW     = crpm_pkg::MASK_W;

    // Handshake chain
    logic [NS:1]   valid_reg;
    logic [NS+1:1] stage_rdy;
    logic [NS:1]   valid_src;

    // Side data carried to the compare stage
    logic [MW-1:0] mask_reg   [1:NS-1];
    logic          active_reg [1:NS-1];

    // Stage 1
    logic signed [D-1:0] x_s, y_s, z_s, ca_s, cb_s, amin_s, amax_s;
    logic signed [D-1:0] axial, radial_b;
    logic [D:0]          da_next, db_next;
    logic [D:0]          da_reg, db_reg;
    logic                active_next;

    // Stage 2
    logic [D:0]   da_neg, db_neg;
    logic [D-1:0] abs_a_reg, abs_b_reg;

    // Stages 3-4 live in the squarers
    logic [2*D-1:0] sq_a, sq_b;

    // Stage 5
    logic [DIST_W-1:0] dist_reg;

    // Stage 6
    logic          hit_next;
    logic [MW-1:0] mask_out_next;
    logic          hit_reg;
    logic [MW-1:0] mask_out_reg;

    // A stage loads when it is empty or its successor takes its content
    always_comb begin
        stage_rdy[NS+1] = out_ready;
        for (int i = NS; i >= 1; i--) begin
            stage_rdy[i] = !valid_reg[i] || stage_rdy[i+1];
        end
    end

    assign valid_src = {valid_reg[NS-1:1], in_valid};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= '0;
        end else begin
            for (int i = 1; i <= NS; i++) begin
                if (stage_rdy[i]) begin
                    valid_reg[i] <= valid_src[i];
                end
            end
        end
    end

    assign in_ready = stage_rdy[1];

    // Stage 1: axis selection, offsets, axial window
    assign x_s    = coord_x;
    assign y_s    = coord_y;
    assign z_s    = coord_z;
    assign ca_s   = center_a;
    assign cb_s   = center_b;
    assign amin_s = axial_min;
    assign amax_s = axial_max;

    assign axial    = axis_select ? y_s : z_s;
    assign radial_b = axis_select ? z_s : y_s;

    assign da_next = {x_s[D-1], x_s} - {ca_s[D-1], ca_s};
    assign db_next = {radial_b[D-1], radial_b} - {cb_s[D-1], cb_s};

    // Masked or invalid points never test; an empty window never hits
    assign active_next = (mask_in == crpm_pkg::MASK_CLEAR)
                      && !(coord_x == '0 && coord_y == '0 && coord_z == '0)
                      && (axial >= amin_s) && (axial <= amax_s);

    always_ff @(posedge aclk) begin
        if (stage_rdy[1]) begin
            da_reg        <= da_next;
            db_reg        <= db_next;
            mask_reg[1]   <= mask_in;
            active_reg[1] <= active_next;
        end
    end

    // Side data shift for stages 2..5
    always_ff @(posedge aclk) begin
        for (int i = 2; i <= NS - 1; i++) begin
            if (stage_rdy[i]) begin
                mask_reg[i]   <= mask_reg[i-1];
                active_reg[i] <= active_reg[i-1];
            end
        end
    end

    // Stage 2: magnitude of the offsets (fits in D bits)
    assign da_neg = -da_reg;
    assign db_neg = -db_reg;

    always_ff @(posedge aclk) begin
        if (stage_rdy[2]) begin
            abs_a_reg <= da_reg[D] ? da_neg[D-1:0] : da_reg[D-1:0];
            abs_b_reg <= db_reg[D] ? db_neg[D-1:0] : db_reg[D-1:0];
        end
    end

    // Stages 3 and 4: exact squares
    crpm_square #(.W(D)) u_sq_a (
        .aclk   (aclk),
        .en_pp  (stage_rdy[3]),
        .en_sum (stage_rdy[4]),
        .val    (abs_a_reg),
        .sq     (sq_a)
    );

    crpm_square #(.W(D)) u_sq_b (
        .aclk   (aclk),
        .en_pp  (stage_rdy[3]),
        .en_sum (stage_rdy[4]),
        .val    (abs_b_reg),
        .sq     (sq_b)
    );

    // Stage 5: squared radial distance
    always_ff @(posedge aclk) begin
        if (stage_rdy[5]) begin
            dist_reg <= DIST_W'(sq_a) + DIST_W'(sq_b);
        end
    end

    // Stage 6: inclusive annulus test and mask update
    assign hit_next = active_reg[NS-1]
                   && (DIST_W'(inner_sq) <= dist_reg)
                   && (dist_reg <= DIST_W'(outer_sq));
    assign mask_out_next = hit_next ? mark_value : mask_reg[NS-1];

    always_ff @(posedge aclk) begin
        if (stage_rdy[NS]) begin
            hit_reg      <= hit_next;
            mask_out_reg <= mask_out_next;
        end
    end

    assign out_valid = valid_reg[NS];
    assign mask_out  = mask_out_reg;
    assign hit       = hit_reg;

endmodule

// ===== src/crpm_checker.sv =====
// Port-level checks on the result stream and pipeline occupancy.
module crpm_checker (
    input logic       aclk,
    input logic       aresetn,
    input logic       s_tvalid,
    input logic       s_tready,
    input logic       m_tvalid,
    input logic       m_tready,
    input logic [7:0] m_tdata,
    input logic [0:0] m_tuser
);

    localparam int CNT_W = 3;

    logic [CNT_W-1:0] cnt_reg;
    logic [CNT_W-1:0] cnt_next;
    logic             in_req, out_req;

    assign in_req   = s_tvalid & s_tready;
    assign out_req  = m_tvalid & m_tready;
    assign cnt_next = cnt_reg + CNT_W'(in_req) - CNT_W'(out_req);

    // Requests in flight
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cnt_reg <= '0;
        end else begin
            cnt_reg <= cnt_next;
        end
    end

    // A stalled result holds
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
        else $error("stalled result changed");

    // Input backpressure only when every stage is full and output stalled
    a_full: assert property (@(posedge aclk) disable iff (!aresetn)
        !s_tready |-> m_tvalid && !m_tready)
        else $error("input stalled with room in the pipeline");

    // No result without a request behind it
    a_origin: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> cnt_reg != '0)
        else $error("result without accepted request");

    // Occupancy never exceeds the stage count
    a_depth: assert property (@(posedge aclk) disable iff (!aresetn)
        cnt_reg <= CNT_W'(crpm_pkg::PIPE_DEPTH))
        else $error("more requests in flight than stages");

endmodule

bind cylinder_region_pixel_mask_top crpm_checker u_crpm_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
);

// ===== tb/region_mask_checker.sv =====
// Watches the point, result and settings buses, predicts each updated mask
// byte from its own copy of the region settings and compares in order.
module region_mask_checker (
    input  logic         aclk,
    input  logic         aresetn,
    // s_tdata: coord_x, coord_y, coord_z, mask_in
    input  logic         s_tvalid,
    input  logic         s_tready,
    input  logic [103:0] s_tdata,
    // m_tdata: mask_out
    input  logic         m_tvalid,
    input  logic         m_tready,
    input  logic [7:0]   m_tdata,
    // m_tuser: hit
    input  logic [0:0]   m_tuser,
    input  logic         psel,
    input  logic         penable,
    input  logic         pwrite,
    input  logic         pready,
    input  logic [4:0]   paddr,
    input  logic [31:0]  pwdata,
    output int           mismatch_count,
    output int           pending
);

    typedef struct packed {
        logic [7:0] mask_out;
        logic       hit;
    } mask_result_t;

    // Region settings as last written over the bus
    logic               axis_y;
    logic signed [31:0] ctr_a;
    logic signed [31:0] ctr_b;
    logic [30:0]        r_inner;
    logic [30:0]        r_outer;
    logic signed [31:0] ax_lo;
    logic signed [31:0] ax_hi;
    logic [7:0]         mark;

    mask_result_t expected_masks[$];
    int           bad_total;

    // Exact square of the distance between a coordinate and the axis position
    function automatic logic [65:0] offset_sq(logic signed [31:0] p, logic signed [31:0] c);
        longint      d;
        logic [65:0] m;
        d = longint'(p) - longint'(c);
        if (d < 0)
            d = -d;
        m = 66'(d);
        return m * m;
    endfunction

    function automatic mask_result_t predict_mask(logic [103:0] pt);
        logic signed [31:0] x;
        logic signed [31:0] y;
        logic signed [31:0] z;
        logic signed [31:0] axial;
        logic signed [31:0] radial;
        logic [7:0]         m_in;
        logic [65:0]        dist_sq;
        logic [65:0]        lo2;
        logic [65:0]        hi2;
        mask_result_t       r;
        x = pt[31:0];
        y = pt[63:32];
        z = pt[95:64];
        m_in = pt[103:96];
        r.mask_out = m_in;
        r.hit = 1'b0;
        // already masked or invalid origin point: pass through
        if (m_in != crpm_pkg::MASK_CLEAR || (x == 0 && y == 0 && z == 0))
            return r;
        axial = axis_y ? y : z;
        radial = axis_y ? z : y;
        if (axial >= ax_lo && axial <= ax_hi) begin
            dist_sq = offset_sq(x, ctr_a) + offset_sq(radial, ctr_b);
            lo2 = 66'(r_inner) * 66'(r_inner);
            hi2 = 66'(r_outer) * 66'(r_outer);
            if (lo2 <= dist_sq && dist_sq <= hi2) begin
                r.mask_out = mark;
                r.hit = 1'b1;
            end
        end
        return r;
    endfunction

    always @(posedge aclk) begin : monitor
        mask_result_t         want;
        mask_result_t         got;
        crpm_pkg::reg_idx_t   idx;
        if (!aresetn) begin
            axis_y  = 1'b0;
            ctr_a   = '0;
            ctr_b   = '0;
            r_inner = '0;
            r_outer = '0;
            ax_lo   = '0;
            ax_hi   = '0;
            mark    = crpm_pkg::MARK_RESET;
            expected_masks.delete();
            bad_total = 0;
        end else begin
            // result request: compare against the oldest prediction
            if (m_tvalid && m_tready) begin
                got.mask_out = m_tdata;
                got.hit = m_tuser[0];
                if (expected_masks.size() == 0) begin
                    if (bad_total < 10)
                        $display("unexpected result: mask_out=%02h hit=%0b",
                                 got.mask_out, got.hit);
                    bad_total++;
                end else begin
                    want = expected_masks.pop_front();
                    if (got !== want) begin
                        if (bad_total < 10)
                            $display({"mask mismatch: expected mask_out=%02h hit=%0b,",
                                      " got mask_out=%02h hit=%0b"},
                                     want.mask_out, want.hit, got.mask_out, got.hit);
                        bad_total++;
                    end
                end
            end
            // point request: predict with the settings in force now
            if (s_tvalid && s_tready)
                expected_masks.push_back(predict_mask(s_tdata));
            // settings write; bits above each register's width are dropped
            if (psel && penable && pwrite && pready) begin
                idx = crpm_pkg::reg_idx_t'(paddr[4:2]);
                case (idx)
                    crpm_pkg::REG_AXIS_SELECT:  axis_y  = pwdata[0];
                    crpm_pkg::REG_CENTER_A:     ctr_a   = pwdata;
                    crpm_pkg::REG_CENTER_B:     ctr_b   = pwdata;
                    crpm_pkg::REG_INNER_RADIUS: r_inner = pwdata[30:0];
                    crpm_pkg::REG_OUTER_RADIUS: r_outer = pwdata[30:0];
                    crpm_pkg::REG_AXIAL_MIN:    ax_lo   = pwdata;
                    crpm_pkg::REG_AXIAL_MAX:    ax_hi   = pwdata;
                    crpm_pkg::REG_MARK_VALUE:   mark    = pwdata[7:0];
                    default: ;
                endcase
            end
        end
        mismatch_count <= bad_total;
        pending <= expected_masks.size();
    end

endmodule

// ===== tb/tb.sv =====
module tb;

    localparam int  POINT_W     = 3 * 32 + crpm_pkg::MASK_W;
    localparam int  STALL_LIMIT = 2000;
    localparam int  SEGMENTS    = 8;
    localparam int  SEG_ITEMS   = 70;
    // one meter in Q16.16
    localparam longint M        = 65536;
    localparam longint S32_MIN  = -64'sd2147483648;
    localparam longint S32_MAX  = 64'sd2147483647;

    typedef enum int {
        REGION_TYPICAL,
        REGION_WIDE,
        REGION_EMPTY_RING,
        REGION_EMPTY_SPAN
    } region_kind_t;

    typedef struct packed {
        logic               axis;
        logic signed [31:0] ca;
        logic signed [31:0] cb;
        logic [30:0]        inner;
        logic [30:0]        outer;
        logic signed [31:0] amin;
        logic signed [31:0] amax;
        logic [7:0]         mark;
    } region_t;

    logic               aclk = 1'b0;
    logic               aresetn = 1'b0;
    logic               s_tvalid = 1'b0;
    logic               s_tready;
    logic [POINT_W-1:0] s_tdata = '0;
    logic               m_tvalid;
    logic               m_tready = 1'b0;
    logic [7:0]         m_tdata;
    logic [0:0]         m_tuser;
    logic               psel = 1'b0;
    logic               penable = 1'b0;
    logic               pwrite = 1'b0;
    logic [4:0]         paddr = '0;
    logic [31:0]        pwdata = '0;
    logic [31:0]        prdata;
    logic               pready;

    int      mismatch_count;
    int      pending;
    int      idle_pct = 0;
    int      stall_pct = 0;
    int      quiet = 0;
    region_t cur;

    cylinder_region_pixel_mask_top dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready)
    );

    region_mask_checker chk (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .s_tvalid       (s_tvalid),
        .s_tready       (s_tready),
        .s_tdata        (s_tdata),
        .m_tvalid       (m_tvalid),
        .m_tready       (m_tready),
        .m_tdata        (m_tdata),
        .m_tuser        (m_tuser),
        .psel           (psel),
        .penable        (penable),
        .pwrite         (pwrite),
        .pready         (pready),
        .paddr          (paddr),
        .pwdata         (pwdata),
        .mismatch_count (mismatch_count),
        .pending        (pending)
    );

    always begin
        #6 aclk = 1'b1;
        #6 aclk = 1'b0;
    end

    // Result side back-pressure
    always @(posedge aclk) begin
        m_tready <= ($urandom_range(0, 99) >= stall_pct);
    end

    // Watchdog: cycles without any accepted request
    always @(posedge aclk) begin
        if (!aresetn || (s_tvalid && s_tready) || (m_tvalid && m_tready)
            || (psel && penable && pready)) begin
            quiet <= 0;
        end else begin
            quiet <= quiet + 1;
            if (quiet >= STALL_LIMIT) begin
                $display("FAIL");
                $finish;
            end
        end
    end

    // Uniform value in [lo, hi]; lo when the range is empty
    function automatic longint pick(longint lo, longint hi);
        longint          span;
        longint unsigned u_span;
        longint unsigned u_r;
        span = hi - lo + 1;
        if (span <= 0)
            return lo;
        u_span = span;
        u_r = {$urandom, $urandom};
        return lo + (u_r % u_span);
    endfunction

    function automatic region_t make_region(logic axis, longint ca, longint cb,
                                            longint inner, longint outer,
                                            longint amin, longint amax, logic [7:0] mark);
        region_t r;
        r.axis  = axis;
        r.ca    = 32'(ca);
        r.cb    = 32'(cb);
        r.inner = 31'(inner);
        r.outer = 31'(outer);
        r.amin  = 32'(amin);
        r.amax  = 32'(amax);
        r.mark  = mark;
        return r;
    endfunction

    function automatic region_t random_region(region_kind_t kind, logic axis);
        region_t r;
        longint  outer_l;
        longint  amin_l;
        r.axis = axis;
        r.mark = ($urandom_range(0, 7) == 0) ? crpm_pkg::MASK_CLEAR
                                             : 8'($urandom_range(1, 255));
        if (kind == REGION_WIDE) begin
            r.ca = $urandom;
            r.cb = $urandom;
            r.outer = $urandom_range(0, 1) ? 31'h7FFFFFFF : 31'($urandom);
            outer_l = longint'(r.outer);
            r.inner = ($urandom_range(0, 3) == 0) ? 31'd0 : 31'(pick(0, outer_l));
            r.amin = 32'(S32_MIN);
            r.amax = 32'(S32_MAX);
        end else begin
            r.ca = 32'(pick(-(1 << 22), 1 << 22));
            r.cb = 32'(pick(-(1 << 22), 1 << 22));
            outer_l = pick(M / 16, 1 << 22);
            r.outer = 31'(outer_l);
            r.inner = $urandom_range(0, 2) == 0 ? 31'd0 : 31'(pick(0, outer_l));
            amin_l = pick(-(1 << 22), 1 << 22);
            r.amin = 32'(amin_l);
            r.amax = 32'(amin_l + pick(0, 1 << 23));
            if (kind == REGION_EMPTY_RING)
                r.inner = 31'(outer_l + pick(1, M));
            if (kind == REGION_EMPTY_SPAN)
                r.amax = 32'(amin_l - pick(1, M));
        end
        return r;
    endfunction

    // Setup then access phase; psel stays high across back-to-back writes
    task automatic write_reg(crpm_pkg::reg_idx_t idx, logic [31:0] val);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= {idx, 2'b00};
        pwdata <= val;
        @(posedge aclk);
        penable <= 1'b1;
        do @(posedge aclk); while (!pready);
    endtask

    // All eight registers, with junk above each register's width
    task automatic program_region(region_t r);
        logic [31:0] junk;
        cur = r;
        junk = $urandom;
        write_reg(crpm_pkg::REG_AXIS_SELECT, {junk[31:1], r.axis});
        write_reg(crpm_pkg::REG_CENTER_A, r.ca);
        write_reg(crpm_pkg::REG_CENTER_B, r.cb);
        write_reg(crpm_pkg::REG_INNER_RADIUS, {junk[0], r.inner});
        write_reg(crpm_pkg::REG_OUTER_RADIUS, {junk[1], r.outer});
        write_reg(crpm_pkg::REG_AXIAL_MIN, r.amin);
        write_reg(crpm_pkg::REG_AXIAL_MAX, r.amax);
        write_reg(crpm_pkg::REG_MARK_VALUE, {junk[31:8], r.mark});
        psel <= 1'b0;
        penable <= 1'b0;
    endtask

    // Coordinates keep their low 32 bits
    task automatic send_point(longint x, longint y, longint z, logic [7:0] m);
        while ($urandom_range(0, 99) < idle_pct) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata <= {m, 32'(z), 32'(y), 32'(x)};
        do @(posedge aclk); while (!s_tready);
    endtask

    // Mostly points around the current region, some on its exact edges
    task automatic send_random_point();
        int     k;
        longint inner_l;
        longint outer_l;
        longint ca_l;
        longint cb_l;
        longint lo_ax;
        longint hi_ax;
        longint rad;
        longint dx;
        longint dr;
        longint slack;
        longint axv;
        longint radial;
        logic [7:0] m;
        k = $urandom_range(0, 99);
        if (k < 6) begin
            send_point($urandom, $urandom, $urandom, 8'($urandom));
            return;
        end
        if (k < 10) begin
            m = $urandom_range(0, 1) ? crpm_pkg::MASK_CLEAR : 8'($urandom_range(1, 255));
            send_point(0, 0, 0, m);
            return;
        end
        m = (k < 22) ? 8'($urandom_range(1, 255)) : crpm_pkg::MASK_CLEAR;
        inner_l = longint'(cur.inner);
        outer_l = longint'(cur.outer);
        ca_l = longint'(cur.ca);
        cb_l = longint'(cur.cb);
        lo_ax = longint'(cur.amin);
        hi_ax = longint'(cur.amax);
        if (hi_ax < lo_ax) begin
            lo_ax = longint'(cur.amax);
            hi_ax = longint'(cur.amin);
        end
        dx = 0;
        dr = 0;
        if (k < 40) begin
            // on a radius or an axial bound, or one step off it
            rad = ($urandom_range(0, 1) ? inner_l : outer_l) + int'($urandom_range(0, 2)) - 1;
            case ($urandom_range(0, 3))
                0: dx = rad;
                1: dx = -rad;
                2: dr = rad;
                default: dr = -rad;
            endcase
            case ($urandom_range(0, 2))
                0: axv = lo_ax - int'($urandom_range(0, 1));
                1: axv = hi_ax + int'($urandom_range(0, 1));
                default: axv = pick(lo_ax, hi_ax);
            endcase
        end else begin
            slack = outer_l / 8 + 2;
            dx = pick(-outer_l - slack, outer_l + slack);
            dr = pick(-outer_l - slack, outer_l + slack);
            slack = (hi_ax - lo_ax) / 8 + 2;
            axv = pick(lo_ax - slack, hi_ax + slack);
        end
        radial = cb_l + dr;
        if (cur.axis)
            send_point(ca_l + dx, axv, radial, m);
        else
            send_point(ca_l + dx, radial, axv, m);
    endtask

    task automatic wait_drained();
        s_tvalid <= 1'b0;
        @(posedge aclk);
        while (pending != 0) @(posedge aclk);
    endtask

    task automatic set_pressure(int src_idle, int dst_stall);
        idle_pct = src_idle;
        stall_pct <= dst_stall;
    endtask

    initial begin : stimulus
        longint       ca;
        longint       cb;
        region_kind_t kind;
        cur = make_region(1'b0, 0, 0, 0, 0, 0, 0, crpm_pkg::MARK_RESET);
        repeat (9) @(posedge aclk);
        aresetn <= 1'b1;

        // reset settings: only the invalid origin lies in the region
        send_point(1, 0, 0, crpm_pkg::MASK_CLEAR);
        send_point(0, 0, 0, crpm_pkg::MASK_CLEAR);
        wait_drained();

        // z-axis ring: edges of both radii and both axial bounds
        ca = 3 * M / 2;
        cb = -2 * M;
        program_region(make_region(1'b0, ca, cb, M, 5 * M, -3 * M, 4 * M, 8'h5A));
        send_point(ca + 5 * M, cb, 0, crpm_pkg::MASK_CLEAR);
        send_point(ca + 5 * M + 1, cb, M, crpm_pkg::MASK_CLEAR);
        send_point(ca - M, cb, M, crpm_pkg::MASK_CLEAR);
        send_point(ca, cb + M - 1, M, crpm_pkg::MASK_CLEAR);
        send_point(ca + 3 * M, cb + 4 * M, -M, crpm_pkg::MASK_CLEAR);
        send_point(ca + 3 * M, cb, -3 * M, crpm_pkg::MASK_CLEAR);
        send_point(ca + 3 * M, cb, -3 * M - 1, crpm_pkg::MASK_CLEAR);
        send_point(ca + 3 * M, cb, 4 * M, crpm_pkg::MASK_CLEAR);
        send_point(ca + 3 * M, cb, 4 * M + 1, crpm_pkg::MASK_CLEAR);
        send_point(ca + 3 * M, cb, 0, 8'h01);
        send_point(ca + 3 * M, cb, 0, 8'hFF);
        // origin is geometrically inside here but invalid
        send_point(0, 0, 0, crpm_pkg::MASK_CLEAR);
        send_point(32'h7FFFFFFF, 32'h80000000, 32'h7FFFFFFF, crpm_pkg::MASK_CLEAR);
        send_point(32'h80000000, 32'h7FFFFFFF, 0, crpm_pkg::MASK_CLEAR);
        wait_drained();

        // y-axis solid cylinder, mark value zero
        program_region(make_region(1'b1, -M, 2 * M, 0, 2 * M, 0, M, crpm_pkg::MASK_CLEAR));
        send_point(-M, 0, 2 * M, crpm_pkg::MASK_CLEAR);
        send_point(-M, M, 4 * M, crpm_pkg::MASK_CLEAR);
        send_point(-M, M + 1, 2 * M, crpm_pkg::MASK_CLEAR);
        send_point(-M, 2 * M, M / 2, crpm_pkg::MASK_CLEAR);
        wait_drained();

        // full-range settings: distances beyond 64 bits
        program_region(make_region(1'b0, S32_MIN, S32_MIN, 0, S32_MAX, S32_MIN, S32_MAX,
                                   8'hA5));
        send_point(32'h80000000, 32'h80000000, 5, crpm_pkg::MASK_CLEAR);
        send_point(32'h7FFFFFFF, 32'h7FFFFFFF, 0, crpm_pkg::MASK_CLEAR);
        send_point(32'hFFFFFFFF, 32'h80000000, 1, crpm_pkg::MASK_CLEAR);
        wait_drained();

        // inner radius above outer
        program_region(make_region(1'b0, 0, 0, 3 * M, 2 * M, -M, M, 8'h33));
        send_point(2 * M, 0, 0, crpm_pkg::MASK_CLEAR);
        wait_drained();

        // axial minimum above maximum
        program_region(make_region(1'b0, 0, 0, 0, 2 * M, M, -M, 8'h33));
        send_point(M, 0, 0, crpm_pkg::MASK_CLEAR);
        wait_drained();

        // random segments, each with its own settings and pressure
        for (int seg = 0; seg < SEGMENTS; seg++) begin
            case (seg)
                2, 7: kind = REGION_WIDE;
                5: kind = REGION_EMPTY_RING;
                6: kind = REGION_EMPTY_SPAN;
                default: kind = REGION_TYPICAL;
            endcase
            program_region(random_region(kind, seg[0]));
            case (seg % 4)
                0: set_pressure(0, 0);
                1: set_pressure(68, 0);
                2: set_pressure(0, 68);
                default: set_pressure(6, 6);
            endcase
            repeat (SEG_ITEMS) send_random_point();
            wait_drained();
        end

        set_pressure(0, 0);
        repeat (crpm_pkg::PIPE_DEPTH + 4) @(posedge aclk);
        if (mismatch_count == 0 && pending == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

endmodule

// ===== sim.f =====
src/crpm_pkg.sv
src/crpm_square.sv
src/crpm_regs.sv
src/crpm_pipe.sv
src/cylinder_region_pixel_mask_top.sv
src/crpm_checker.sv
tb/region_mask_checker.sv
tb/tb.sv
